// File: rtl/bvm_pkg.sv
package bvm_pkg;

    // Field widths
    localparam int READING_W  = 12;
    localparam int MV_W       = 16;
    localparam int CAL_W      = 12;
    localparam int GAIN_W     = 14;
    localparam int OFFSET_W   = 10;
    localparam int COEFF_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic constants
    localparam int ADC_BITS_DEF  = 12;
    localparam int GAIN_FRAC     = 12;
    localparam int SUPPLY_REF_MV = 3000;
    localparam int NUM_W         = 24;   // holds 3000 * (2^12 - 1)
    localparam int PROD_W        = GAIN_W + MV_W + READING_W;

    // Register reset values
    localparam logic [CAL_W-1:0]    REF_CAL_RST = CAL_W'(1655);
    localparam logic [GAIN_W-1:0]   GAIN_RST    = GAIN_W'(6185);
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = OFFSET_W'(90);
    localparam logic [COEFF_W-1:0]  COEFF_RST   = COEFF_W'(128);
    localparam logic [MV_W-1:0]     WARM_RST    = MV_W'(1000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_CAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_SAMPLE,
        ST_FILT,
        ST_OUT
    } t_state;

endpackage

// File: rtl/bvm_div.sv
module bvm_div
    import bvm_pkg::*;
#(
    parameter int N_W = NUM_W,
    parameter int D_W = READING_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0] r_num;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;

    logic [D_W:0] w_trial;
    logic [D_W:0] w_diff;
    logic         w_ge;

    // One restoring step: bring down the next numerator bit, subtract if it fits
    assign w_trial = {r_rem, r_num[N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[N_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/bvm_mul.sv
module bvm_mul
    import bvm_pkg::*;
#(
    parameter int A_W = GAIN_W,
    parameter int B_W = MV_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [P_W-1:0]   r_mcand;
    logic [B_W-1:0]   r_mplier;
    logic [P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add: one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= P_W'(i_a);
            r_mplier <= i_b;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[P_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/bvm_ema.sv
module bvm_ema
    import bvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MV_W-1:0]    i_sample,
    input  logic [MV_W-1:0]    i_level,
    input  logic [COEFF_W-1:0] i_coeff,
    output logic               o_done,
    output logic [MV_W-1:0]    o_level
);

    localparam int ACC_W = MV_W + COEFF_W + 2;
    localparam int CNT_W = $clog2(COEFF_W + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_diff;
    logic [COEFF_W-1:0]      r_coeff;

    logic signed [MV_W:0] w_diff0;

    // level*256 + c*(sample - level) equals c*sample + (256 - c)*level
    assign w_diff0 = $signed({1'b0, i_sample}) - $signed({1'b0, i_level});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COEFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= $signed({2'b00, i_level, {COEFF_W{1'b0}}});
            r_diff  <= ACC_W'(w_diff0);
            r_coeff <= i_coeff;
        end else if (r_busy) begin
            if (r_coeff[0]) begin
                r_acc <= r_acc + r_diff;
            end
            r_diff  <= r_diff <<< 1;
            r_coeff <= {1'b0, r_coeff[COEFF_W-1:1]};
        end
    end

    // Weighted mean stays between sample and level, so no saturation is needed
    assign o_done  = r_done;
    assign o_level = r_acc[MV_W+COEFF_W-1:COEFF_W];

endmodule

// File: rtl/battery_voltage_monitor.sv
// Path to result valid: 24 divider steps, 16 + 12 multiplier steps, then 8 filter
// steps unless warm-up skips the filter, plus control.
// One item at a time: the input stays stalled until the bit-serial divider, the
// shift-add multipliers and the filter are done and the result is loaded, which a stalled output delays.
// Reset (i_rst_n low, synchronous): clear control and the filtered level, load
// the configuration registers with their default values.
module battery_voltage_monitor
    import bvm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [READING_W-1:0]  i_reference_reading,
    input  logic [READING_W-1:0]  i_battery_reading,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MV_W-1:0]       o_filtered_mv,
    output logic [MV_W-1:0]       o_sample_mv,
    output logic [MV_W-1:0]       o_supply_mv
);

    // Battery product is gain (Q12) * supply * reading over full scale
    localparam int SHIFT = GAIN_FRAC + ADC_BITS;

    // Configuration registers
    logic [CAL_W-1:0]    r_ref_cal;
    logic [GAIN_W-1:0]   r_gain;
    logic [OFFSET_W-1:0] r_offset;
    logic [COEFF_W-1:0]  r_coeff;
    logic [MV_W-1:0]     r_warm;

    // Sequencer
    t_state r_state;
    t_state n_state;

    logic w_in_xfer;
    logic w_mul1_start;
    logic w_mul2_start;
    logic w_ema_start;
    logic w_warm_load;
    logic w_out_load;

    // Datapath
    logic [READING_W-1:0] r_ref;
    logic [READING_W-1:0] r_bat;
    logic [MV_W-1:0]      r_supply;
    logic [MV_W-1:0]      r_sample;
    logic [MV_W-1:0]      r_level;
    logic                 r_out_valid;

    logic [NUM_W-1:0]          w_num;
    logic                      w_div_done;
    logic [NUM_W-1:0]          w_quo;
    logic [MV_W-1:0]           w_supply;
    logic                      w_mul1_done;
    logic [GAIN_W+MV_W-1:0]    w_prod1;
    logic                      w_mul2_done;
    logic [PROD_W-1:0]         w_prod2;
    logic [PROD_W-1:0]         w_scaled;
    logic [MV_W:0]             w_sum;
    logic [MV_W-1:0]           w_sample_sat;
    logic [MV_W-1:0]           w_sample;
    logic                      w_ema_done;
    logic [MV_W-1:0]           w_ema_level;

    //------------------------------------------------------------------
    // Configuration: the user must keep writes to idle; the block does not enforce it and uses the registers live
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_cal <= REF_CAL_RST;
            r_gain    <= GAIN_RST;
            r_offset  <= OFFSET_RST;
            r_coeff   <= COEFF_RST;
            r_warm    <= WARM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_CAL: r_ref_cal <= i_cfg_data[CAL_W-1:0];
                CFG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET:  r_offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_COEFF:   r_coeff   <= i_cfg_data[COEFF_W-1:0];
                CFG_WARM:    r_warm    <= i_cfg_data[MV_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Sequencer: one item at a time, divider started by the input transfer, each later unit after the previous done
    //------------------------------------------------------------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_mul1_start = 1'b0;
        w_mul2_start = 1'b0;
        w_ema_start  = 1'b0;
        w_warm_load  = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_mul1_start = 1'b1;
                    n_state      = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (w_mul1_done) begin
                    w_mul2_start = 1'b1;
                    n_state      = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (w_mul2_done) begin
                    n_state = ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                // Level under the warm-up threshold: take the sample as is
                if (r_level < r_warm) begin
                    w_warm_load = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    w_ema_start = 1'b1;
                    n_state     = ST_FILT;
                end
            end
            ST_FILT: begin
                if (w_ema_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the result register once it is empty or being drained
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Supply voltage: 3000 * cal / ref, bit-serial restoring divide
    //------------------------------------------------------------------
    assign w_num = NUM_W'(r_ref_cal) * NUM_W'(SUPPLY_REF_MV);

    bvm_div #(
        .N_W (NUM_W),
        .D_W (READING_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_num   (w_num),
        .i_den   (i_reference_reading),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Zero reference reading gives zero supply; otherwise saturate to 16 bits
    always_comb begin
        if (r_ref == '0) begin
            w_supply = '0;
        end else if (|w_quo[NUM_W-1:MV_W]) begin
            w_supply = '1;
        end else begin
            w_supply = w_quo[MV_W-1:0];
        end
    end

    //------------------------------------------------------------------
    // Battery term: gain * supply, then * battery reading, both shift-add
    //------------------------------------------------------------------
    bvm_mul #(
        .A_W (GAIN_W),
        .B_W (MV_W)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul1_start),
        .i_a     (r_gain),
        .i_b     (w_supply),
        .o_done  (w_mul1_done),
        .o_prod  (w_prod1)
    );

    bvm_mul #(
        .A_W (GAIN_W + MV_W),
        .B_W (READING_W)
    ) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul2_start),
        .i_a     (w_prod1),
        .i_b     (r_bat),
        .o_done  (w_mul2_done),
        .o_prod  (w_prod2)
    );

    // Drop the fraction, add the offset, saturate, then clamp up to the supply
    assign w_scaled     = w_prod2 >> SHIFT;
    assign w_sum        = {1'b0, w_scaled[MV_W-1:0]} + (MV_W + 1)'(r_offset);
    assign w_sample_sat = (|w_scaled[PROD_W-1:MV_W] || w_sum[MV_W]) ? '1 : w_sum[MV_W-1:0];
    assign w_sample     = (w_sample_sat < r_supply) ? r_supply : w_sample_sat;

    //------------------------------------------------------------------
    // Exponential filter: Q8 weighted mean, one coefficient bit per cycle
    //------------------------------------------------------------------
    bvm_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_ema_start),
        .i_sample (r_sample),
        .i_level  (r_level),
        .i_coeff  (r_coeff),
        .o_done   (w_ema_done),
        .o_level  (w_ema_level)
    );

    //------------------------------------------------------------------
    // Datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ref <= i_reference_reading;
            r_bat <= i_battery_reading;
        end
        if (w_mul1_start) begin
            r_supply <= w_supply;
        end
        if (r_state == ST_MUL2 && w_mul2_done) begin
            r_sample <= w_sample;
        end
    end

    // Filtered level is the only datapath value carried from one item into the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (w_warm_load) begin
            r_level <= r_sample;
        end else if (r_state == ST_FILT && w_ema_done) begin
            r_level <= w_ema_level;
        end
    end

    // Result register: holds while stalled, frees on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_filtered_mv <= r_level;
            o_sample_mv   <= r_sample;
            o_supply_mv   <= r_supply;
        end
    end

    assign o_out_valid = r_out_valid;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // An accepted item blocks the input until its result is loaded
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input not stalled after transfer");

    // A new result only comes from the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result valid without sequencer load");

    // Sample is never below the supply it was clamped to
    a_sample_ge_supply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_mv >= o_supply_mv))
        else $error("sample below supply");

    // The filtered level changes only at the sample or filter step
    a_level_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_level) |-> ($past(r_state == ST_SAMPLE) || $past(r_state == ST_FILT)))
        else $error("level changed outside update step");

endmodule
